// ===== sv/met_pkg.sv =====
// Shared types, widths and constants for the Mandelbrot escape-time block.
package met_pkg;

  // Fixed-point format of c and of the iterate z
  localparam int FRACTION_BITS = 28;
  localparam int COORD_W       = 32;                 // input coordinate width
  localparam int Z_W           = 64;                 // iterate component width
  localparam int HALF_W        = Z_W / 2;            // multiplier operand width
  localparam int PROD_W        = 2 * Z_W;            // exact product width
  localparam int SUM_W         = PROD_W + 1;         // sum / difference of two products
  localparam int WIDE_W        = SUM_W + 1;          // headroom for the add of c

  localparam int COUNT_W       = 16;
  localparam int RADIUS_W      = 11;
  localparam int R2_W          = 2 * RADIUS_W;

  // Configuration port
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_RADIUS   = CFG_INDEX_W'(1);
  localparam logic [COUNT_W-1:0]     LIMIT_RESET         = COUNT_W'(100);
  localparam logic [RADIUS_W-1:0]    RADIUS_RESET        = RADIUS_W'(1000);

  // Job queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH   = 2;
  localparam int QADDR_W       = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W       = QADDR_W + 1;

  // Serial multiplier: four 32x32 partial products per 64x64 product
  localparam int MUL_STEPS     = 4;
  localparam int MUL_STEP_W    = $clog2(MUL_STEPS + 1);

  // Most points that can be inside the block: queue, back end, output register
  localparam int FLIGHT_MAX    = QUEUE_DEPTH + 2;
  localparam int FLIGHT_W      = $clog2(FLIGHT_MAX + 1);

  typedef struct packed {
    logic [COUNT_W-1:0]  limit;
    logic [RADIUS_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] c_re;
    logic [COORD_W-1:0] c_im;
    logic               trivial;   // limit of one or less: no iteration runs
  } job_t;

  typedef struct packed {
    logic           start;
    logic [Z_W-1:0] a;
    logic [Z_W-1:0] b;
  } mul_req_t;

  // Clamp a wide signed value to the signed range of an iterate component
  function automatic logic [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-Z_W:0] top;
    logic [Z_W-1:0]      res;
    top = v[WIDE_W-1:Z_W-1];
    if (top == '0 || top == '1) begin
      res = v[Z_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(Z_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== sv/met_front.sv =====
// Front end: configuration registers, input acceptance and job classification.
module met_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [met_pkg::COORD_W-1:0]    point_real,
  input  logic [met_pkg::COORD_W-1:0]    point_imag,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [met_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           q_full,
  output logic                           q_push,
  output met_pkg::job_t                  q_data,
  output met_pkg::cfg_t                  cfg
);

  logic [met_pkg::COUNT_W-1:0]  limit;
  logic [met_pkg::RADIUS_W-1:0] radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= met_pkg::LIMIT_RESET;
      radius <= met_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        met_pkg::REG_ITERATION_LIMIT: limit  <= cfg_data;
        met_pkg::REG_ESCAPE_RADIUS:   radius <= cfg_data[met_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.limit  = limit;
  assign cfg.radius = radius;

  assign in_ready       = !q_full;
  assign q_push         = in_valid && !q_full;
  assign q_data.c_re    = point_real;
  assign q_data.c_im    = point_imag;
  assign q_data.trivial = (limit <= met_pkg::COUNT_W'(1));

endmodule

// ===== sv/met_queue.sv =====
// Short job queue that decouples the front end from the iteration engine.
module met_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  met_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output met_pkg::job_t pop_data,
  output logic          empty
);

  met_pkg::job_t                entries [met_pkg::QUEUE_DEPTH];
  logic [met_pkg::QADDR_W-1:0]  wr_ptr;
  logic [met_pkg::QADDR_W-1:0]  rd_ptr;
  logic [met_pkg::QFILL_W-1:0]  fill;

  assign full     = (fill == met_pkg::QFILL_W'(met_pkg::QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + met_pkg::QADDR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + met_pkg::QADDR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + met_pkg::QFILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - met_pkg::QFILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/met_mul.sv =====
// Serial 64x64 unsigned multiplier built on one registered 32x32 multiplier.
module met_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  met_pkg::mul_req_t            req,
  output logic                         done,
  output logic [met_pkg::PROD_W-1:0]   product
);

  localparam int HW = met_pkg::HALF_W;
  localparam int ZW = met_pkg::Z_W;
  localparam int PW = met_pkg::PROD_W;

  logic                             busy;
  logic [met_pkg::MUL_STEP_W-1:0]   step;
  logic [ZW-1:0]                    pp;
  logic [1:0]                       pp_sel;
  logic [PW-1:0]                    acc;
  logic [HW-1:0]                    a_half;
  logic [HW-1:0]                    b_half;
  logic [ZW-1:0]                    pp_now;
  logic [PW-1:0]                    pp_aligned;

  // step 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
  assign a_half = step[1] ? req.a[ZW-1:HW] : req.a[HW-1:0];
  assign b_half = step[0] ? req.b[ZW-1:HW] : req.b[HW-1:0];
  assign pp_now = ZW'(a_half) * ZW'(b_half);

  always_comb begin
    case (pp_sel)
      2'd0:    pp_aligned = {{(PW-ZW){1'b0}}, pp};
      2'd3:    pp_aligned = {pp, {(PW-ZW){1'b0}}};
      default: pp_aligned = {{(PW-ZW-HW){1'b0}}, pp, {HW{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + met_pkg::MUL_STEP_W'(1);
        if (step == met_pkg::MUL_STEP_W'(met_pkg::MUL_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial product registered, then accumulated in the next cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
    end else if (busy && step != '0) begin
      acc <= acc + pp_aligned;
    end
    if (busy && step < met_pkg::MUL_STEP_W'(met_pkg::MUL_STEPS)) begin
      pp     <= pp_now;
      pp_sel <= step[1:0];
    end
  end

  assign product = acc;

endmodule

// ===== sv/met_core.sv =====
// Back end: escape-time iteration engine with output register.
module met_core (
  input  logic                         clk,
  input  logic                         rst,
  input  met_pkg::cfg_t                cfg,
  input  logic                         q_empty,
  input  met_pkg::job_t                q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [met_pkg::COUNT_W-1:0]  escape_count
);

  localparam int ZW = met_pkg::Z_W;
  localparam int CW = met_pkg::COORD_W;
  localparam int PW = met_pkg::PROD_W;
  localparam int SW = met_pkg::SUM_W;
  localparam int WW = met_pkg::WIDE_W;
  localparam int NW = met_pkg::COUNT_W;
  localparam int F  = met_pkg::FRACTION_BITS;

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_MAG     = 13'b0000000000010,
    ST_XX_GO   = 13'b0000000000100,
    ST_XX_WAIT = 13'b0000000001000,
    ST_YY_GO   = 13'b0000000010000,
    ST_YY_WAIT = 13'b0000000100000,
    ST_SUM     = 13'b0000001000000,
    ST_TEST    = 13'b0000010000000,
    ST_XY_GO   = 13'b0000100000000,
    ST_XY_WAIT = 13'b0001000000000,
    ST_DIFF    = 13'b0010000000000,
    ST_UPDATE  = 13'b0100000000000,
    ST_RESULT  = 13'b1000000000000
  } state_t;

  state_t                    state;
  logic signed [ZW-1:0]      c_re;
  logic signed [ZW-1:0]      c_im;
  logic signed [ZW-1:0]      x;
  logic signed [ZW-1:0]      y;
  logic [ZW-1:0]             mx;
  logic [ZW-1:0]             my;
  logic [PW-1:0]             xx;
  logic [PW-1:0]             yy;
  logic [PW-1:0]             xy;
  logic signed [SW-1:0]      diff;
  logic signed [PW-1:0]      xy_s;
  logic [SW-1:0]             sum;
  logic [met_pkg::R2_W-1:0]  r2;
  logic [NW-1:0]             iter;
  logic [NW-1:0]             count;
  logic                      tested;

  met_pkg::mul_req_t         mul_req;
  logic                      mul_done;
  logic [PW-1:0]             mul_product;

  logic                      xx_op;
  logic                      yy_op;
  logic                      slot_free;
  logic signed [WW-1:0]      diff_x;
  logic signed [WW-1:0]      xy_x;
  logic signed [WW-1:0]      cre_x;
  logic signed [WW-1:0]      cim_x;
  logic signed [WW-1:0]      re_w;
  logic signed [WW-1:0]      im_w;
  logic [SW-1:0]             thr;
  logic [NW:0]               iter_inc;

  met_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_product)
  );

  assign xx_op         = (state == ST_XX_GO) || (state == ST_XX_WAIT);
  assign yy_op         = (state == ST_YY_GO) || (state == ST_YY_WAIT);
  assign mul_req.start = (state == ST_XX_GO) || (state == ST_YY_GO) || (state == ST_XY_GO);
  assign mul_req.a     = yy_op ? my : mx;
  assign mul_req.b     = xx_op ? mx : my;

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign slot_free = !out_valid || out_ready;

  // floor shift of the product terms, then add of c
  assign diff_x = {{(WW-SW){diff[SW-1]}}, diff};
  assign xy_x   = {{(WW-PW){xy_s[PW-1]}}, xy_s};
  assign cre_x  = {{(WW-ZW){c_re[ZW-1]}}, c_re};
  assign cim_x  = {{(WW-ZW){c_im[ZW-1]}}, c_im};
  assign re_w   = (diff_x >>> F) + cre_x;
  assign im_w   = (xy_x >>> (F - 1)) + cim_x;

  assign thr      = SW'(r2) << (2 * F);
  assign iter_inc = {1'b0, iter} + (NW + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_RESULT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= q_data.trivial ? ST_RESULT : ST_MAG;
          end
        end
        ST_MAG:     state <= ST_XX_GO;
        ST_XX_GO:   state <= ST_XX_WAIT;
        ST_XX_WAIT: if (mul_done) state <= ST_YY_GO;
        ST_YY_GO:   state <= ST_YY_WAIT;
        ST_YY_WAIT: if (mul_done) state <= tested ? ST_SUM : ST_XY_GO;
        ST_SUM:     state <= ST_TEST;
        ST_TEST: begin
          if (sum > thr || iter_inc >= {1'b0, cfg.limit}) begin
            state <= ST_RESULT;
          end else begin
            state <= ST_XY_GO;
          end
        end
        ST_XY_GO:   state <= ST_XY_WAIT;
        ST_XY_WAIT: if (mul_done) state <= ST_DIFF;
        ST_DIFF:    state <= ST_UPDATE;
        ST_UPDATE:  state <= ST_MAG;
        ST_RESULT:  if (slot_free) state <= ST_IDLE;
        default:    state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        c_re   <= {{(ZW-CW){q_data.c_re[CW-1]}}, q_data.c_re};
        c_im   <= {{(ZW-CW){q_data.c_im[CW-1]}}, q_data.c_im};
        x      <= {{(ZW-CW){q_data.c_re[CW-1]}}, q_data.c_re};
        y      <= {{(ZW-CW){q_data.c_im[CW-1]}}, q_data.c_im};
        r2     <= met_pkg::R2_W'(cfg.radius) * met_pkg::R2_W'(cfg.radius);
        iter   <= NW'(1);
        tested <= 1'b0;
        count  <= '0;
      end
      ST_MAG: begin
        mx <= x[ZW-1] ? -x : x;
        my <= y[ZW-1] ? -y : y;
      end
      ST_XX_WAIT: if (mul_done) xx <= mul_product;
      ST_YY_WAIT: if (mul_done) yy <= mul_product;
      ST_SUM:     sum <= {1'b0, xx} + {1'b0, yy};
      ST_TEST: begin
        if (sum > thr) begin
          count <= iter;
        end else begin
          iter <= iter_inc[NW-1:0];
        end
      end
      ST_XY_WAIT: if (mul_done) xy <= mul_product;
      ST_DIFF: begin
        diff <= {1'b0, xx} - {1'b0, yy};
        xy_s <= (x[ZW-1] ^ y[ZW-1]) ? -xy : xy;
      end
      ST_UPDATE: begin
        x      <= met_pkg::sat_z(re_w);
        y      <= met_pkg::sat_z(im_w);
        tested <= 1'b1;
      end
      ST_RESULT: if (slot_free) escape_count <= count;
      default: ;
    endcase
  end

endmodule

// ===== sv/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time counter: one complex point in, one iteration count out.
// Points with a limit of 0 or 1 run no iteration; the engine works on one point at a time.
// Each iteration runs 12 partial products through the one shared 32x32 multiplier,
//   plus add, shift and compare steps.
// Reset (rst, synchronous): registers return to limit 100 and radius 1000, queue empties.
module mandelbrot_escape_time (
  input  logic                            clk,
  input  logic                            rst,
  // point input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [met_pkg::COORD_W-1:0]     point_real,
  input  logic [met_pkg::COORD_W-1:0]     point_imag,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [met_pkg::COUNT_W-1:0]     escape_count,
  // register write channel: index 0 is the iteration limit, index 1 the radius
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [met_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // front to queue
  logic          q_full;
  logic          q_push;
  met_pkg::job_t q_in;
  // queue to engine
  logic          q_pop;
  logic          q_empty;
  met_pkg::job_t q_out;
  // live register values
  met_pkg::cfg_t cfg;

  // Front end: takes a transfer whenever the queue has room, tags points that
  // need no iteration so the engine can answer them at once.
  met_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .point_real (point_real),
    .point_imag (point_imag),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in),
    .cfg        (cfg)
  );

  // Two-entry queue: the front keeps taking points while the engine iterates.
  met_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Engine: z = z*z + c with exact 128-bit products, escape test on |z|^2
  // against R^2; the result sits in an output register until its transfer.
  met_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .escape_count (escape_count)
  );

endmodule

// ===== sv/met_checker.sv =====
// Port-level checks for the escape-time block, bound to the top level.
module met_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [met_pkg::COUNT_W-1:0] escape_count
);

  logic [met_pkg::FLIGHT_W-1:0] flight;

  // points taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      flight <= '0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   flight <= flight + met_pkg::FLIGHT_W'(1);
        2'b01:   flight <= flight - met_pkg::FLIGHT_W'(1);
        default: flight <= flight;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(escape_count))
    else $error("result changed or dropped while stalled");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> flight != '0)
    else $error("result shown with no point outstanding");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    flight == met_pkg::FLIGHT_W'(met_pkg::FLIGHT_MAX) |-> !in_ready)
    else $error("input taken with every stage occupied");

endmodule

bind mandelbrot_escape_time met_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .escape_count (escape_count)
);
